// ===== rtl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants for the positional list engine
// Holds the operation and status codes, the port widths and the command
// that the controller broadcasts along the row of storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  localparam int POS_W          = 7;   // position and entry_count ports
  localparam int PORT_DATA_W    = 32;  // value and read_data ports
  localparam int OP_W           = 2;
  localparam int STATUS_W       = 2;
  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int GROUP          = 8;   // cells merged per read-gather register

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_MODIFY = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // Command seen by every cell; the write flags are only set for a checked request
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic             mdf;
    logic [POS_W-1:0] position;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell: one storage cell of the list
// Holds the entry at a fixed list position. If addressed it takes the new value
// on insert or modify and shows its entry on the read tap; if above, on insert
// its lower neighbour's entry; at or above, on remove its upper neighbour's.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_cell #(
  parameter int INDEX      = 0,
  parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
  input  wire                        clk,
  input  wire ple_pkg::cell_cmd_t    cmd,
  input  wire logic [DATA_WIDTH-1:0] wr_value,
  input  wire logic [DATA_WIDTH-1:0] prev_data,
  input  wire logic [DATA_WIDTH-1:0] next_data,
  output logic      [DATA_WIDTH-1:0] data,
  output logic      [DATA_WIDTH-1:0] tap
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (IDX_W > ple_pkg::POS_W) ? IDX_W : ple_pkg::POS_W;

  logic [CMP_W-1:0] idx_c;
  logic [CMP_W-1:0] pos_c;
  logic             hit;
  logic             above;

  assign idx_c = CMP_W'(INDEX);
  assign pos_c = CMP_W'(cmd.position);
  assign hit   = (idx_c == pos_c);
  assign above = (idx_c > pos_c);

  always_ff @(posedge clk) begin
    priority if (cmd.ins && hit) begin
      data <= wr_value;
    end else if (cmd.ins && above) begin
      data <= prev_data;
    end else if (cmd.rem && (hit || above)) begin
      data <= next_data;
    end else if (cmd.mdf && hit) begin
      data <= wr_value;
    end
  end

  assign tap = hit ? data : '0;

endmodule

`default_nettype wire

// ===== rtl/ple_gather.sv =====
// ----------------------------------------------------------------------------
// ple_gather: first level of the read collection
// ORs the cell taps in groups and registers each group, so the read path
// to the result register only has to merge the group registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_gather #(
  parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF,
  parameter int NGRP       = (CAPACITY + ple_pkg::GROUP - 1) / ple_pkg::GROUP
) (
  input  wire                        clk,
  input  wire                        load,
  input  wire logic [DATA_WIDTH-1:0] tap [CAPACITY],
  output logic      [DATA_WIDTH-1:0] grp [NGRP]
);

  logic [DATA_WIDTH-1:0] grp_next [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < ple_pkg::GROUP; k++) begin
        if (g * ple_pkg::GROUP + k < CAPACITY) begin
          grp_next[g] = grp_next[g] | tap[g * ple_pkg::GROUP + k];
        end
      end
    end
  end

  // hold the groups while the result waits for the output register
  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine: bounded ordered list with positional access
// Requests arrive on in_valid/in_stall with operation, position and value;
// each gives one result on out_valid/out_stall with read_data, status and
// entry_count. A transfer happens on a clock edge with valid high and stall
// low.
// The list is a row of CAPACITY cells. Insert and remove shift the cells at
// and above the position by one place in the cycle of the input transfer;
// modify writes the addressed cell in that same cycle.
// The result of a request passes through the read gather register and the
// pending registers into the output register. A new request is taken only
// once the previous one's result has entered the output register.
// in_stall is high while a request waits for the output register; the
// output register frees as its result is transferred, so while the receiver
// stalls at most one further request is taken.
// Reset (rst, synchronous) empties the list and drops any pending result;
// cell contents are not cleared, positions at or above the count are never
// read.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine #(
  parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  wire logic [ple_pkg::OP_W-1:0]          operation,
  input  wire logic [ple_pkg::POS_W-1:0]         position,
  input  wire logic signed [ple_pkg::PORT_DATA_W-1:0] value,
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output logic signed [ple_pkg::PORT_DATA_W-1:0] read_data,
  output logic      [ple_pkg::STATUS_W-1:0]      status,
  output logic      [ple_pkg::POS_W-1:0]         entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W;
  localparam int NGRP  = (CAPACITY + ple_pkg::GROUP - 1) / ple_pkg::GROUP;
  localparam int RD_W  = (DATA_WIDTH < ple_pkg::PORT_DATA_W) ? DATA_WIDTH
                                                             : ple_pkg::PORT_DATA_W;

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic                    accept;
  logic [CMP_W-1:0]        pos_c;
  logic [CMP_W-1:0]        cnt_c;
  ple_pkg::op_t            op;
  ple_pkg::status_t        st;
  logic                    do_ins;
  logic                    do_rem;
  logic                    do_mdf;
  ple_pkg::cell_cmd_t      cmd;
  logic [DATA_WIDTH-1:0]   wr_value;

  // request waiting for the output register
  logic                    pend;
  ple_pkg::status_t        p_status;
  logic [CNT_W-1:0]        p_count;
  logic                    p_read;
  logic                    p_badread;
  logic                    out_load;

  logic [DATA_WIDTH-1:0]   cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0]   cell_tap  [CAPACITY];
  logic [DATA_WIDTH-1:0]   grp       [NGRP];
  logic [DATA_WIDTH-1:0]   gathered;
  logic [DATA_WIDTH-1:0]   rd_word;

  assign in_stall = pend;
  assign accept   = in_valid && !in_stall;
  assign op       = ple_pkg::op_t'(operation);
  assign pos_c    = CMP_W'(position);
  assign cnt_c    = CMP_W'(count);
  assign wr_value = DATA_WIDTH'(value);

  always_comb begin
    st         = ple_pkg::ST_OK;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    do_mdf     = 1'b0;
    count_next = count;
    unique case (op)
      ple_pkg::OP_INSERT: begin
        if (pos_c > cnt_c) begin
          st = ple_pkg::ST_BADPOS;
        end else if (cnt_c == CMP_W'(CAPACITY)) begin
          st = ple_pkg::ST_FULL;
        end else begin
          do_ins     = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      ple_pkg::OP_REMOVE: begin
        if (pos_c >= cnt_c) begin
          st = ple_pkg::ST_BADPOS;
        end else begin
          do_rem     = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      ple_pkg::OP_READ: begin
        if (pos_c >= cnt_c) begin
          st = ple_pkg::ST_BADPOS;
        end
      end
      ple_pkg::OP_MODIFY: begin
        if (pos_c >= cnt_c) begin
          st = ple_pkg::ST_BADPOS;
        end else begin
          do_mdf = 1'b1;
        end
      end
      default: begin
        st = ple_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    cmd.ins      = accept && do_ins;
    cmd.rem      = accept && do_rem;
    cmd.mdf      = accept && do_mdf;
    cmd.position = position;
  end

  // row of cells, each wired to its neighbours (zero past either end)
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_data;
    logic [DATA_WIDTH-1:0] next_data;

    if (i == 0) begin : g_first
      assign prev_data = '0;
    end else begin : g_prev
      assign prev_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_next
      assign next_data = cell_data[i+1];
    end

    ple_cell #(
      .INDEX      (i),
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .wr_value  (wr_value),
      .prev_data (prev_data),
      .next_data (next_data),
      .data      (cell_data[i]),
      .tap       (cell_tap[i])
    );
  end

  ple_gather #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .NGRP       (NGRP)
  ) u_gather (
    .clk  (clk),
    .load (accept),
    .tap  (cell_tap),
    .grp  (grp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= 1'b1;
    end else if (out_load) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_status  <= st;
      p_count   <= count_next;
      p_read    <= (op == ple_pkg::OP_READ);
      p_badread <= (st == ple_pkg::ST_BADPOS);
    end
  end

  always_comb begin
    gathered = '0;
    for (int g = 0; g < NGRP; g++) begin
      gathered = gathered | grp[g];
    end
    rd_word = p_badread ? '1 : gathered;
  end

  assign out_load = pend && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_data   <= p_read ? ple_pkg::PORT_DATA_W'(rd_word[RD_W-1:0]) : '0;
      status      <= p_status;
      entry_count <= ple_pkg::POS_W'(p_count);
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench for positional_list_engine
// Runs a table of directed requests (empty list, extreme values, bad and wide
// positions, a fill to capacity and inserts into the full list), then random
// grow, shrink and mixed phases. Each result is checked per field against its
// row or a behavioural list copy, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;

  localparam int CAP         = ple_pkg::CAPACITY_DEF;
  localparam int POS_W       = ple_pkg::POS_W;
  localparam int PORT_DATA_W = ple_pkg::PORT_DATA_W;
  localparam int OP_W        = ple_pkg::OP_W;
  localparam int STATUS_W    = ple_pkg::STATUS_W;
  localparam int RAND_ITEMS  = 1600;
  localparam int LIMIT       = 400000;

  typedef ple_pkg::op_t     op_t;
  typedef ple_pkg::status_t status_t;

  typedef struct {
    logic signed [PORT_DATA_W-1:0] rd;
    status_t                       st;
    logic [POS_W-1:0]              cnt;
  } list_result_t;

  typedef struct {
    op_t                           op;
    logic [POS_W-1:0]              pos;
    logic signed [PORT_DATA_W-1:0] val;
    bit                            rnd_val;
    int                            reps;
    bit                            typed;
    list_result_t                  res;
  } list_row_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [OP_W-1:0]               operation;
  logic [POS_W-1:0]              position;
  logic signed [PORT_DATA_W-1:0] value;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [PORT_DATA_W-1:0] read_data;
  logic [STATUS_W-1:0]           status;
  logic [POS_W-1:0]              entry_count;

  // Behavioural copy of the list
  logic signed [PORT_DATA_W-1:0] list_mem [0:CAP-1];
  int                            list_len;

  list_result_t pending_results [$];
  list_row_t    directed_rows [$];

  int  errors;
  int  results_seen;
  int  cycle_cnt;
  int  op_count [4];
  int  badpos_hits;
  int  full_hits;
  int  peak_len;
  bit  quiet;
  int  stall_left;

  positional_list_engine i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .position    (position),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .status      (status),
    .entry_count (entry_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones; none during a quiet phase
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic list_result_t list_apply(op_t op, logic [POS_W-1:0] pos,
                                              logic signed [PORT_DATA_W-1:0] val);
    list_result_t r;
    r.rd = '0;
    r.st = ple_pkg::ST_OK;
    case (op)
      ple_pkg::OP_INSERT: begin
        if (pos > list_len) begin
          r.st = ple_pkg::ST_BADPOS;
        end else if (list_len >= CAP) begin
          r.st = ple_pkg::ST_FULL;
        end else begin
          for (int i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = val;
          list_len++;
        end
      end
      ple_pkg::OP_REMOVE: begin
        if (pos >= list_len) begin
          r.st = ple_pkg::ST_BADPOS;
        end else begin
          for (int i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      ple_pkg::OP_READ: begin
        if (pos >= list_len) begin
          r.st = ple_pkg::ST_BADPOS;
          r.rd = '1;
        end else begin
          r.rd = list_mem[pos];
        end
      end
      default: begin
        if (pos >= list_len) r.st = ple_pkg::ST_BADPOS;
        else list_mem[pos] = val;
      end
    endcase
    r.cnt = POS_W'(list_len);
    return r;
  endfunction

  task automatic add_row(op_t op, int pos, logic signed [PORT_DATA_W-1:0] val,
                         bit rnd_val, int reps, bit typed,
                         logic signed [PORT_DATA_W-1:0] rd, status_t st, int cnt);
    list_row_t row;
    row.op      = op;
    row.pos     = POS_W'(pos);
    row.val     = val;
    row.rnd_val = rnd_val;
    row.reps    = reps;
    row.typed   = typed;
    row.res.rd  = rd;
    row.res.st  = st;
    row.res.cnt = POS_W'(cnt);
    directed_rows.push_back(row);
  endtask

  // Hold the request until its transfer, then update the list copy
  task automatic send_request(op_t op, logic [POS_W-1:0] pos,
                              logic signed [PORT_DATA_W-1:0] val,
                              bit typed, list_result_t typed_res);
    list_result_t pred;
    int           gap;
    in_valid  <= 1'b1;
    operation <= op;
    position  <= pos;
    value     <= val;
    do @(posedge clk); while (in_stall);
    pred = list_apply(op, pos, val);
    pending_results.push_back(typed ? typed_res : pred);
    op_count[op]++;
    if (pred.st == ple_pkg::ST_BADPOS) badpos_hits++;
    if (pred.st == ple_pkg::ST_FULL) full_hits++;
    if (list_len > peak_len) peak_len = list_len;
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver stalls
  always @(posedge clk) begin : stall_gen
    int g;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      g = rand_gap();
      out_stall  <= (g > 0);
      stall_left <= g;
    end
  end

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result with nothing pending: read_data=%h status=%0d entry_count=%0d",
                   read_data, status, entry_count);
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (read_data !== want.rd || status !== want.st || entry_count !== want.cnt) begin
          errors++;
          if (errors <= 10)
            $display("mismatch on result %0d: read_data %h/%h status %0d/%0d count %0d/%0d",
                     results_seen, want.rd, read_data, want.st, status,
                     want.cnt, entry_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_cnt, pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    list_result_t none;
    op_t          op;
    int           kind;
    int           phase_len;
    int           sent;
    int           r;
    int           hi;
    logic [POS_W-1:0]              pos;
    logic signed [PORT_DATA_W-1:0] val;

    rst        <= 1'b1;
    in_valid   <= 1'b0;
    operation  <= ple_pkg::OP_INSERT;
    position   <= '0;
    value      <= '0;
    out_stall  <= 1'b0;
    errors     = 0;
    cycle_cnt  = 0;
    stall_left = 0;
    quiet      = 1'b0;
    list_len   = 0;
    peak_len   = 0;
    none       = '{rd: '0, st: ple_pkg::ST_OK, cnt: '0};

    // Empty list, extremes, wide positions
    add_row(ple_pkg::OP_READ,     0, 0,            0, 1, 1, -1,           ple_pkg::ST_BADPOS, 0);
    add_row(ple_pkg::OP_REMOVE,   0, 0,            0, 1, 1, 0,            ple_pkg::ST_BADPOS, 0);
    add_row(ple_pkg::OP_MODIFY,   0, 5,            0, 1, 1, 0,            ple_pkg::ST_BADPOS, 0);
    add_row(ple_pkg::OP_INSERT,   1, 9,            0, 1, 1, 0,            ple_pkg::ST_BADPOS, 0);
    add_row(ple_pkg::OP_INSERT,   0, 32'h7FFFFFFF, 0, 1, 1, 0,            ple_pkg::ST_OK,     1);
    add_row(ple_pkg::OP_INSERT,   0, 32'h80000000, 0, 1, 1, 0,            ple_pkg::ST_OK,     2);
    add_row(ple_pkg::OP_READ,     0, 0,            0, 1, 1, 32'h80000000, ple_pkg::ST_OK,     2);
    add_row(ple_pkg::OP_READ,     1, 0,            0, 1, 1, 32'h7FFFFFFF, ple_pkg::ST_OK,     2);
    add_row(ple_pkg::OP_INSERT,   2, -1,           0, 1, 1, 0,            ple_pkg::ST_OK,     3);
    add_row(ple_pkg::OP_READ,   127, 0,            0, 1, 1, -1,           ple_pkg::ST_BADPOS, 3);
    add_row(ple_pkg::OP_READ,     3, 0,            0, 1, 1, -1,           ple_pkg::ST_BADPOS, 3);
    add_row(ple_pkg::OP_MODIFY,   1, 0,            0, 1, 1, 0,            ple_pkg::ST_OK,     3);
    add_row(ple_pkg::OP_READ,     1, 0,            0, 1, 1, 0,            ple_pkg::ST_OK,     3);
    add_row(ple_pkg::OP_REMOVE,   0, 0,            0, 1, 1, 0,            ple_pkg::ST_OK,     2);
    add_row(ple_pkg::OP_READ,     0, 0,            0, 1, 0, 0,            ple_pkg::ST_OK,     0);
    add_row(ple_pkg::OP_REMOVE,   1, 0,            0, 1, 1, 0,            ple_pkg::ST_OK,     1);
    add_row(ple_pkg::OP_INSERT,  64, 0,            0, 1, 1, 0,            ple_pkg::ST_BADPOS, 1);
    // Fill to capacity, then push against the full list
    add_row(ple_pkg::OP_INSERT,   0, 0,            1, 63, 0, 0,           ple_pkg::ST_OK,     0);
    add_row(ple_pkg::OP_INSERT,  64, 1,            0, 1, 1, 0,            ple_pkg::ST_FULL,   64);
    add_row(ple_pkg::OP_INSERT,   0, 1,            0, 1, 1, 0,            ple_pkg::ST_FULL,   64);
    add_row(ple_pkg::OP_INSERT,  65, 1,            0, 1, 1, 0,            ple_pkg::ST_BADPOS, 64);
    add_row(ple_pkg::OP_READ,    63, 0,            0, 1, 0, 0,            ple_pkg::ST_OK,     0);
    add_row(ple_pkg::OP_MODIFY,  63, 0,            1, 1, 0, 0,            ple_pkg::ST_OK,     0);
    add_row(ple_pkg::OP_REMOVE,  64, 0,            0, 1, 1, 0,            ple_pkg::ST_BADPOS, 64);
    add_row(ple_pkg::OP_REMOVE,  63, 0,            0, 1, 1, 0,            ple_pkg::ST_OK,     63);
    add_row(ple_pkg::OP_READ,     0, 0,            0, 1, 0, 0,            ple_pkg::ST_OK,     0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      for (int n = 0; n < directed_rows[k].reps; n++) begin
        send_request(directed_rows[k].op, directed_rows[k].pos,
                     directed_rows[k].rnd_val ? $signed($urandom) : directed_rows[k].val,
                     directed_rows[k].typed, directed_rows[k].res);
      end
    end
    in_valid <= 1'b0;
    wait_drained();

    // Random phases: grow, shrink or mixed traffic, some of them without idling
    sent = 0;
    while (sent < RAND_ITEMS) begin
      kind      = $urandom_range(0, 2);
      phase_len = $urandom_range(40, 160);
      quiet     = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        wait_drained();
      end
      for (int n = 0; n < phase_len && sent < RAND_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        case (kind)
          0:       op = r < 60 ? ple_pkg::OP_INSERT : r < 70 ? ple_pkg::OP_REMOVE :
                        r < 85 ? ple_pkg::OP_READ : ple_pkg::OP_MODIFY;
          1:       op = r < 60 ? ple_pkg::OP_REMOVE : r < 70 ? ple_pkg::OP_INSERT :
                        r < 85 ? ple_pkg::OP_READ : ple_pkg::OP_MODIFY;
          default: op = op_t'(r % 4);
        endcase
        hi = (op == ple_pkg::OP_INSERT) ? list_len : (list_len > 0 ? list_len - 1 : 0);
        r  = $urandom_range(0, 9);
        if (r < 8) pos = POS_W'($urandom_range(0, hi));
        else if (r == 8) pos = POS_W'($urandom_range(0, 127));
        else pos = POS_W'(list_len + $urandom_range(0, 1));
        r = $urandom_range(0, 9);
        if (r < 8) val = $signed($urandom);
        else if (r == 8) val = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
        else val = $urandom_range(0, 1) ? 32'sh0 : -32'sh1;
        send_request(op, pos, val, 1'b0, none);
        sent++;
      end
    end
    in_valid <= 1'b0;
    quiet    = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);

    $display("Checked %0d results: insert %0d, remove %0d, read %0d, modify %0d",
             results_seen, op_count[ple_pkg::OP_INSERT], op_count[ple_pkg::OP_REMOVE],
             op_count[ple_pkg::OP_READ], op_count[ple_pkg::OP_MODIFY]);
    $display("Bad positions %0d, full-list rejections %0d, peak length %0d, mismatches %0d",
             badpos_hits, full_hits, peak_len, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/ple_gather.sv
rtl/positional_list_engine.sv
dv/tb.sv
